@@ rtl/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the infix-to-postfix converter
// Operator codes, character classes, stack sizing and the result record.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int CODE_W      = 3;

    // Operator stack codes
    localparam logic [CODE_W-1:0] CODE_OPEN  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_PLUS  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_MINUS = 3'd2;
    localparam logic [CODE_W-1:0] CODE_MUL   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DIV   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_POW   = 3'd5;

    // Result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STS_UNMATCHED = 2'd2;

    // ASCII characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CHECK,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_ALNUM,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP,
        CLS_ZERO
    } cls_t;

    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        logic       done;
        logic [1:0] status;
    } result_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CODE_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    function automatic cls_t classify(input logic [7:0] c);
        cls_t k;
        begin
            k = CLS_OTHER;
            if (c == CH_NUL)
                k = CLS_ZERO;
            else if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                     (c >= 8'h61 && c <= 8'h7A))
                k = CLS_ALNUM;
            else if (c == CH_OPEN)
                k = CLS_OPEN;
            else if (c == CH_CLOSE)
                k = CLS_CLOSE;
            else if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV ||
                     c == CH_POW)
                k = CLS_OP;
            return k;
        end
    endfunction

    function automatic logic [CODE_W-1:0] op_code(input logic [7:0] c);
        logic [CODE_W-1:0] k;
        begin
            case (c)
                CH_PLUS:  k = CODE_PLUS;
                CH_MINUS: k = CODE_MINUS;
                CH_MUL:   k = CODE_MUL;
                CH_DIV:   k = CODE_DIV;
                CH_POW:   k = CODE_POW;
                default:  k = CODE_OPEN;
            endcase
            return k;
        end
    endfunction

    function automatic logic [7:0] code_char(input logic [CODE_W-1:0] k);
        logic [7:0] c;
        begin
            case (k)
                CODE_OPEN:  c = CH_OPEN;
                CODE_PLUS:  c = CH_PLUS;
                CODE_MINUS: c = CH_MINUS;
                CODE_MUL:   c = CH_MUL;
                CODE_DIV:   c = CH_DIV;
                CODE_POW:   c = CH_POW;
                default:    c = CH_NUL;
            endcase
            return c;
        end
    endfunction

    function automatic logic [2:0] code_prec(input logic [CODE_W-1:0] k);
        logic [2:0] p;
        begin
            case (k)
                CODE_PLUS, CODE_MINUS: p = 3'd1;
                CODE_MUL, CODE_DIV:    p = 3'd3;
                CODE_POW:              p = 3'd4;
                default:               p = 3'd0;
            endcase
            return p;
        end
    endfunction

endpackage

@@ rtl/itp_stack_ram.sv @@
// ----------------------------------------------------------------------------
// itp_stack_ram: operator stack storage
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module itp_stack_ram (
    input  logic                          clk,
    input  itp_pkg::ram_req_t             req,
    output logic [itp_pkg::CODE_W-1:0]    rd_data
);
    import itp_pkg::*;

    logic [CODE_W-1:0] mem [STACK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

@@ rtl/itp_out_stage.sv @@
// ----------------------------------------------------------------------------
// itp_out_stage: result output register
// Holds one result towards the receiver; takes a new one whenever it drains.
// ----------------------------------------------------------------------------
module itp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  itp_pkg::result_t  load_res,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_stall,
    output itp_pkg::result_t  out_res
);
    import itp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= load_res;
    end

endmodule

@@ rtl/itp_ctrl.sv @@
// ----------------------------------------------------------------------------
// itp_ctrl: shunting-yard sequencer
// Reads the stack top, decides pop or push, and holds each result back one
// step so that the last result of a request can be marked.
// ----------------------------------------------------------------------------
module itp_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    symbol,
    output itp_pkg::ram_req_t             ram_req,
    input  logic [itp_pkg::CODE_W-1:0]    rd_data,
    output logic                          load,
    output itp_pkg::result_t              load_res,
    input  logic                          can_load
);
    import itp_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    cls_t              cls_reg;
    logic [7:0]        sym_reg;
    logic [CODE_W-1:0] op_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    result_t           pend_reg;
    result_t           pend_next;

    logic              cnt_zero;
    logic              cnt_full;
    logic              stop_op;
    logic              emit_req;
    logic              blocked;
    logic              flush_ok;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  count_dec;
    result_t           new_res;

    assign cnt_zero  = (count_reg == '0);
    assign cnt_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign count_inc = CNT_W'(count_reg + 1'b1);
    assign count_dec = CNT_W'(count_reg - 1'b1);
    assign stop_op   = (rd_data == CODE_OPEN) || (code_prec(rd_data) < code_prec(op_reg));
    assign in_stall  = (state_reg != ST_IDLE);
    assign flush_ok  = !pend_valid_reg || can_load;

    // What the current step produces, if anything
    always_comb
    begin
        emit_req = 1'b0;
        new_res  = '{sym: CH_NUL, last: 1'b0, done: 1'b0, status: STS_OK};
        case (state_reg)
            ST_DECIDE:
            begin
                case (cls_reg)
                    CLS_ALNUM:
                    begin
                        emit_req    = 1'b1;
                        new_res.sym = sym_reg;
                    end
                    CLS_OPEN:
                    begin
                        emit_req       = cnt_full;
                        new_res.status = STS_OVERFLOW;
                    end
                    CLS_ZERO:
                    begin
                        emit_req     = cnt_zero;
                        new_res.done = 1'b1;
                    end
                    CLS_CLOSE:
                    begin
                        emit_req       = cnt_zero;
                        new_res.status = STS_UNMATCHED;
                    end
                    default:
                    begin
                        emit_req = 1'b0;
                    end
                endcase
            end
            ST_CHECK:
            begin
                new_res.sym = code_char(rd_data);
                case (cls_reg)
                    CLS_ZERO:  emit_req = 1'b1;
                    CLS_CLOSE: emit_req = (rd_data != CODE_OPEN);
                    CLS_OP:
                    begin
                        emit_req = !stop_op || cnt_full;
                        if (stop_op)
                        begin
                            new_res.sym    = CH_NUL;
                            new_res.status = STS_OVERFLOW;
                        end
                    end
                    default:   emit_req = 1'b0;
                endcase
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    // Hold when a held-back result must move out but the output is occupied
    assign blocked = emit_req && pend_valid_reg && !can_load;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!blocked)
                begin
                    case (cls_reg)
                        CLS_ALNUM: state_next = ST_FINISH;
                        CLS_OPEN:  state_next = cnt_full ? ST_FINISH : ST_IDLE;
                        CLS_ZERO,
                        CLS_CLOSE,
                        CLS_OP:    state_next = cnt_zero ? ST_FINISH : ST_CHECK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (!blocked)
                begin
                    case (cls_reg)
                        CLS_CLOSE:
                            state_next = (rd_data == CODE_OPEN) ? ST_FINISH : ST_DECIDE;
                        CLS_OP:
                            state_next = stop_op ? ST_FINISH : ST_DECIDE;
                        default:
                            state_next = ST_DECIDE;
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (flush_ok)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Stack, held-back result and output load
    always_comb
    begin
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        load            = 1'b0;
        load_res        = pend_reg;
        ram_req         = '{wr_en: 1'b0, wr_addr: count_reg[ADDR_W-1:0],
                            wr_data: op_reg, rd_en: 1'b0,
                            rd_addr: count_dec[ADDR_W-1:0]};

        if (emit_req && !blocked)
        begin
            if (pend_valid_reg)
            begin
                load          = 1'b1;
                load_res.last = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = new_res;
        end

        case (state_reg)
            ST_DECIDE:
            begin
                if (!blocked)
                begin
                    case (cls_reg)
                        CLS_OPEN:
                        begin
                            if (!cnt_full)
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_data = CODE_OPEN;
                                count_next      = count_inc;
                            end
                        end
                        CLS_ZERO,
                        CLS_CLOSE:
                        begin
                            ram_req.rd_en = !cnt_zero;
                        end
                        CLS_OP:
                        begin
                            // Empty stack: push at once, depth is at least two
                            if (cnt_zero)
                            begin
                                ram_req.wr_en = 1'b1;
                                count_next    = count_inc;
                            end
                            else
                            begin
                                ram_req.rd_en = 1'b1;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (!blocked)
                begin
                    case (cls_reg)
                        CLS_OP:
                        begin
                            if (!stop_op)
                                count_next = count_dec;
                            else if (!cnt_full)
                            begin
                                ram_req.wr_en = 1'b1;
                                count_next    = count_inc;
                            end
                        end
                        default:
                        begin
                            count_next = count_dec;
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (pend_valid_reg && can_load)
                begin
                    load            = 1'b1;
                    load_res.last   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            cls_reg        <= CLS_OTHER;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (state_reg == ST_IDLE && in_valid)
                cls_reg <= classify(symbol);
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            sym_reg <= symbol;
            op_reg  <= op_code(symbol);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("operator stack count beyond depth");

    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result loaded into an occupied output register");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held-back result left over at the end of a request");

    a_read_check: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.rd_en |=> (state_reg == ST_CHECK))
        else $error("stack read not followed by a top check");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> !cnt_zero)
        else $error("top check on an empty stack");

endmodule

@@ rtl/infix_to_postfix_converter_core.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core: streaming infix to postfix converter
// Shunting-yard conversion of an ASCII character stream using an operator stack.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / symbol) takes one character per request.
// Output channel (out_valid / out_stall / out_symbol, run_last, expr_done,
// status) returns the postfix results in order; run_last marks the last result
// of each input request, and characters that cause nothing give no result.
// Operands pass through a held-back result register into the output register.
// Each stack pop first reads the top entry from the stack memory (registered
// read) and then decides and emits, so a request that pops entries holds the
// input stalled through every read and decision in its sequence. A zero
// character drains the whole stack and then sends the terminator with
// expr_done set. Overflow (push dropped) and an unmatched ')' each end the
// request with an error result carrying status. Reset empties the stack at
// once; its memory is not cleared, since only entries below the count are ever
// read. When the receiver stalls, the current result holds in the output
// register, one more result waits inside, and the input stays stalled until
// the last result of the request has entered the output register.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_symbol,
    output logic       run_last,
    output logic       expr_done,
    output logic [1:0] status
);
    import itp_pkg::*;

    ram_req_t          ram_req;
    logic [CODE_W-1:0] rd_data;
    logic              load;
    result_t           load_res;
    logic              can_load;
    result_t           out_res;

    itp_stack_ram u_stack_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .symbol   (symbol),
        .ram_req  (ram_req),
        .rd_data  (rd_data),
        .load     (load),
        .load_res (load_res),
        .can_load (can_load)
    );

    itp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_res  (load_res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign out_symbol = out_res.sym;
    assign run_last   = out_res.last;
    assign expr_done  = out_res.done;
    assign status     = out_res.status;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: infix to postfix converter core
// Streams ASCII characters into the converter and checks every postfix result
// against a shunting-yard predictor kept alongside. It covers directed
// expressions, operator stack overflow, unmatched and stray parentheses, and
// random expressions under several idle profiles and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] symbol = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_symbol;
    logic       run_last;
    logic       expr_done;
    logic [1:0] status;

    infix_to_postfix_converter_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .symbol     (symbol),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_symbol (out_symbol),
        .run_last   (run_last),
        .expr_done  (expr_done),
        .status     (status)
    );

    // Predictor state
    logic [CODE_W-1:0] op_stack [STACK_DEPTH];
    int                stack_fill = 0;
    result_t           postfix_q [$];
    result_t           pend_res;
    bit                pend_ok = 1'b0;

    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int hold_off_left = 0;
    int quiet_cycles  = 0;
    int items_sent    = 0;
    int n_results     = 0;
    int n_terminators = 0;
    int n_error_res   = 0;
    int fail_count    = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] char_for_code(input logic [CODE_W-1:0] k);
        logic [7:0] c;
        case (k)
            CODE_OPEN:  c = CH_OPEN;
            CODE_PLUS:  c = CH_PLUS;
            CODE_MINUS: c = CH_MINUS;
            CODE_MUL:   c = CH_MUL;
            CODE_DIV:   c = CH_DIV;
            CODE_POW:   c = CH_POW;
            default:    c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic int rank_of(input logic [CODE_W-1:0] k);
        int r;
        case (k)
            CODE_PLUS, CODE_MINUS: r = 1;
            CODE_MUL, CODE_DIV:    r = 3;
            CODE_POW:              r = 4;
            default:               r = 0;
        endcase
        return r;
    endfunction

    // Hold back the newest result so that the last one of a request can be marked
    function automatic void queue_postfix(input logic [7:0] sym, input logic done,
                                          input logic [1:0] st);
        if (pend_ok)
            postfix_q.push_back(pend_res);
        pend_res.sym    = sym;
        pend_res.last   = 1'b0;
        pend_res.done   = done;
        pend_res.status = st;
        pend_ok = 1'b1;
    endfunction

    function automatic bit push_code(input logic [CODE_W-1:0] k);
        if (stack_fill >= STACK_DEPTH)
            return 1'b0;
        op_stack[stack_fill] = k;
        stack_fill++;
        return 1'b1;
    endfunction

    function automatic void convert_symbol(input logic [7:0] c);
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] top;
        bit                is_op;
        bit                found;
        is_op = 1'b1;
        found = 1'b0;
        case (c)
            CH_PLUS:  code = CODE_PLUS;
            CH_MINUS: code = CODE_MINUS;
            CH_MUL:   code = CODE_MUL;
            CH_DIV:   code = CODE_DIV;
            CH_POW:   code = CODE_POW;
            default:
            begin
                code  = CODE_OPEN;
                is_op = 1'b0;
            end
        endcase
        if (c == CH_NUL)
        begin
            while (stack_fill > 0)
            begin
                stack_fill--;
                queue_postfix(char_for_code(op_stack[stack_fill]), 1'b0, STS_OK);
            end
            queue_postfix(CH_NUL, 1'b1, STS_OK);
        end
        else if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
            queue_postfix(c, 1'b0, STS_OK);
        else if (c == CH_OPEN)
        begin
            if (!push_code(CODE_OPEN))
                queue_postfix(CH_NUL, 1'b0, STS_OVERFLOW);
        end
        else if (c == CH_CLOSE)
        begin
            while (stack_fill > 0)
            begin
                stack_fill--;
                top = op_stack[stack_fill];
                if (top == CODE_OPEN)
                begin
                    found = 1'b1;
                    break;
                end
                queue_postfix(char_for_code(top), 1'b0, STS_OK);
            end
            if (!found)
                queue_postfix(CH_NUL, 1'b0, STS_UNMATCHED);
        end
        else if (is_op)
        begin
            while (stack_fill > 0)
            begin
                top = op_stack[stack_fill - 1];
                if (top == CODE_OPEN || rank_of(top) < rank_of(code))
                    break;
                stack_fill--;
                queue_postfix(char_for_code(top), 1'b0, STS_OK);
            end
            if (!push_code(code))
                queue_postfix(CH_NUL, 1'b0, STS_OVERFLOW);
        end
        if (pend_ok)
        begin
            pend_res.last = 1'b1;
            postfix_q.push_back(pend_res);
            pend_ok = 1'b0;
        end
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_symbol(input logic [7:0] c);
        while ($urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= c;
        do
            @(posedge clk);
        while (in_stall);
        convert_symbol(c);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_operand();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 61);
        if (r < 10)
            c = 8'h30 + r[7:0];
        else if (r < 36)
            c = 8'h41 + r[7:0] - 8'd10;
        else
            c = 8'h61 + r[7:0] - 8'd36;
        return c;
    endfunction

    function automatic logic [7:0] pick_operator();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0:       c = CH_PLUS;
            1:       c = CH_MINUS;
            2:       c = CH_MUL;
            3:       c = CH_DIV;
            default: c = CH_POW;
        endcase
        return c;
    endfunction

    // Well-formed expression with random content; now and then noise, a stray
    // '(' left at the end or a surplus ')'
    task automatic send_random_expression();
        int         terms;
        int         open_cnt;
        int         r;
        logic [7:0] noise;
        terms    = $urandom_range(1, 7);
        open_cnt = 0;
        for (int i = 0; i < terms; i++)
        begin
            while (open_cnt < 8 && $urandom_range(0, 3) == 0)
            begin
                send_symbol(CH_OPEN);
                open_cnt++;
            end
            send_symbol(pick_operand());
            if ($urandom_range(0, 9) == 0)
            begin
                noise = $urandom_range(0, 255);
                send_symbol(noise);
            end
            while (open_cnt > 0 && $urandom_range(0, 2) == 0)
            begin
                send_symbol(CH_CLOSE);
                open_cnt--;
            end
            if (i < terms - 1)
                send_symbol(pick_operator());
        end
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            while (open_cnt > 0)
            begin
                send_symbol(CH_CLOSE);
                open_cnt--;
            end
        end
        else if (r == 7)
            send_symbol(CH_CLOSE);
        send_symbol(CH_NUL);
    endtask

    task automatic test_directed_cases();
        logic [7:0] seq [$];
        // Equal precedence pops, a bracketed group, a surplus ')', characters
        // outside every class, a stray '(' at the end and an empty expression
        seq = '{"A", CH_PLUS, "z", CH_MUL, "0", CH_POW, "9", CH_MINUS, CH_OPEN, "b",
                CH_DIV, "c", CH_CLOSE, CH_CLOSE, 8'h20, 8'hFF, 8'h80, 8'h7F, 8'h3A,
                8'h40, CH_OPEN, CH_NUL, CH_NUL};
        foreach (seq[i])
            send_symbol(seq[i]);
    endtask

    task automatic test_stack_overflow();
        // Fill past the top with '(' then with an operator
        for (int i = 0; i < STACK_DEPTH + 2; i++)
            send_symbol(CH_OPEN);
        send_symbol(CH_MUL);
        send_symbol(CH_CLOSE);
        send_symbol(CH_POW);
        send_symbol(CH_MINUS);
        send_symbol("x");
        // Flush a full stack, then a ')' on an empty one
        send_symbol(CH_NUL);
        send_symbol(CH_CLOSE);
        send_symbol(CH_NUL);
    endtask

    task automatic test_random_expressions(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
            send_random_expression();
    endtask

    task automatic test_output_backpressure();
        // Hold the output while requests keep coming, so the core fills up
        hold_off_left = HOLD_OFF_CYCLES;
        for (int i = 0; i < 4; i++)
            send_random_expression();
    endtask

    always @(posedge clk)
    begin
        if (hold_off_left > 0)
            hold_off_left--;
    end

    always @(negedge clk)
        out_stall <= (hold_off_left > 0) || ($urandom_range(0, 99) < rx_stall_pct);

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (postfix_q.size() == 0)
                note_failure($sformatf("unexpected result sym=%02h last=%0b done=%0b st=%0d",
                                       out_symbol, run_last, expr_done, status));
            else
            begin
                want = postfix_q.pop_front();
                if (want.done)
                    n_terminators++;
                if (want.status != STS_OK)
                    n_error_res++;
                if (out_symbol !== want.sym || run_last !== want.last ||
                    expr_done !== want.done || status !== want.status)
                    note_failure($sformatf(
                        "sym %02h/%02h last %0b/%0b done %0b/%0b st %0d/%0d (exp/act)",
                        want.sym, out_symbol, want.last, run_last,
                        want.done, expr_done, want.status, status));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        tx_gap_pct   = 38;
        rx_stall_pct = 72;
        test_directed_cases();
        test_stack_overflow();
        test_random_expressions(100);

        tx_gap_pct   = 72;
        rx_stall_pct = 38;
        test_random_expressions(100);

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        test_random_expressions(100);
        test_output_backpressure();

        in_valid <= 1'b0;
        while (postfix_q.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        if (postfix_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", postfix_q.size()));

        $display("summary: %0d characters sent, %0d postfix results checked",
                 items_sent, n_results);
        $display("summary: %0d expressions terminated, %0d error results, %0d mismatches",
                 n_terminators, n_error_res, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/itp_pkg.sv
rtl/itp_stack_ram.sv
rtl/itp_out_stage.sv
rtl/itp_ctrl.sv
rtl/infix_to_postfix_converter_core.sv
tb/testbench.sv
